@@ rtl/core/b2da_pkg.sv @@
package b2da_pkg;

  // Width of the value port and of the part of it that is converted
  localparam int IN_WIDTH    = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int EFF_WIDTH   = (VALUE_WIDTH < IN_WIDTH) ? VALUE_WIDTH : IN_WIDTH;

  // Decimal digits needed for the largest converted value
  localparam int NUM_DIGITS = (EFF_WIDTH * 30103) / 100000 + 1;
  localparam int DIGIT_W    = 4;
  localparam int BCD_WIDTH  = NUM_DIGITS * DIGIT_W;

  // One counter serves both the bit loop and the digit scan
  localparam int CNT_MAX = (EFF_WIDTH > NUM_DIGITS) ? EFF_WIDTH : NUM_DIGITS;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);

  localparam int CHAR_W = 6;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

  localparam logic [IN_WIDTH-1:0] VALUE_MASK = {IN_WIDTH{1'b1}} >> (IN_WIDTH - EFF_WIDTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  // Commands from the sequencer to the shift unit
  typedef struct packed {
    logic load;
    logic dabble;
    logic digit_shift;
  } unit_ctl_t;

endpackage

@@ rtl/core/binary_to_decimal_ascii.sv @@
// Converts an unsigned value to decimal ASCII text, most significant digit
// first, with leading zeros dropped; zero gives the single character '0'.
// A request is taken when start is high and busy is low. Each character
// appears for one cycle with digit_strobe high, and last_digit marks the
// final one; the receiver cannot stall, so it must take every strobe.
// Each request is loaded in the cycle that takes it, then runs one cycle
// per input bit through the shared shift-add-3 unit, then one cycle per
// decimal digit position while leading zeros are skipped and the remaining
// digits are sent. busy falls after the last.
module binary_to_decimal_ascii
  import b2da_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [IN_WIDTH-1:0] number_value,
  output logic                busy,
  output logic                digit_strobe,
  output logic [CHAR_W-1:0]   digit_char,
  output logic                last_digit
);

  state_t             state, state_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic               started, started_next;
  unit_ctl_t          ctl;
  logic [DIGIT_W-1:0] top_digit;

  b2da_dabble u_dabble (
    .clk        (clk),
    .ctl        (ctl),
    .load_value (number_value),
    .top_digit  (top_digit)
  );

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cnt     <= '0;
      started <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      started <= started_next;
    end
  end

  // Sequence load, bit loop and digit scan
  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    started_next = started;
    ctl          = '0;
    digit_strobe = 1'b0;
    last_digit   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          ctl.load     = 1'b1;
          cnt_next     = CNT_W'(EFF_WIDTH);
          started_next = 1'b0;
          state_next   = ST_CONV;
        end
      end
      ST_CONV: begin
        ctl.dabble = 1'b1;
        cnt_next   = cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          cnt_next   = CNT_W'(NUM_DIGITS);
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        ctl.digit_shift = 1'b1;
        cnt_next        = cnt - CNT_W'(1);
        // Drop leading zeros, but always send the units digit
        if (started || top_digit != '0 || cnt == CNT_W'(1)) begin
          digit_strobe = 1'b1;
          started_next = 1'b1;
        end
        if (cnt == CNT_W'(1)) begin
          last_digit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy       = (state != ST_IDLE);
  assign digit_char = ASCII_ZERO + CHAR_W'(top_digit);

endmodule

@@ rtl/core/b2da_dabble.sv @@
module b2da_dabble
  import b2da_pkg::*;
(
  input  logic                 clk,
  input  unit_ctl_t            ctl,
  input  logic [IN_WIDTH-1:0]  load_value,
  output logic [DIGIT_W-1:0]   top_digit
);

  logic [EFF_WIDTH-1:0] bin;
  logic [BCD_WIDTH-1:0] bcd;
  logic [BCD_WIDTH-1:0] bcd_adj;

  // Add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  // Load, shift one binary bit in, or advance one digit toward the top
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      bin <= EFF_WIDTH'(load_value & VALUE_MASK);
      bcd <= '0;
    end else if (ctl.dabble) begin
      {bcd, bin} <= {bcd_adj[BCD_WIDTH-2:0], bin, 1'b0};
    end else if (ctl.digit_shift) begin
      bcd <= {bcd[BCD_WIDTH-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end
  end

  assign top_digit = bcd[BCD_WIDTH-1 -: DIGIT_W];

endmodule

@@ rtl/core/b2da_checker.sv @@
module b2da_checker
  import b2da_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                digit_strobe,
  input logic [CHAR_W-1:0]   digit_char,
  input logic                last_digit
);

  // Characters are decimal digits only
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    digit_strobe |-> (digit_char >= CHAR_W'(48) && digit_char <= CHAR_W'(57)))
    else $error("digit_char out of range");

  // Characters only appear during a request
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    digit_strobe |-> busy)
    else $error("strobe while idle");

  // The last character ends the request
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (digit_strobe && last_digit) |=> !busy)
    else $error("busy after last digit");

  // Busy only drops after a last character or a reset
  a_fall_cause: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> ($past(rst) || $past(digit_strobe && last_digit)))
    else $error("busy fell without last digit");

  // An accepted request raises busy
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request not taken");

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .digit_strobe (digit_strobe),
  .digit_char   (digit_char),
  .last_digit   (last_digit)
);
